### rtl/bond_fence_polygon_select_defines.svh
// Assertion macros for the fence polygon bond selector checker.
// Each macro expects signals named clock and reset where it is used.
`ifndef BOND_FENCE_POLYGON_SELECT_DEFINES_SVH
`define BOND_FENCE_POLYGON_SELECT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFPS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bfps: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BFPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bfps: next-cycle check failed");

`endif

### rtl/bfps_pkg.sv
// Package for the fence polygon bond selector: sizes, codes, word types
// and the command and status structs between controller and datapath. No dependencies.
package bfps_pkg;

   localparam int MAX_FENCE_VERTICES = 64;
   localparam int COORD_BITS         = 24;
   localparam int ADDR_BITS          = $clog2(MAX_FENCE_VERTICES);
   localparam int CNT_BITS           = $clog2(MAX_FENCE_VERTICES + 1);
   localparam int DIFF_BITS          = COORD_BITS + 1;
   localparam int PROD_BITS          = 2 * DIFF_BITS;
   localparam int TAG_BITS           = 32;
   localparam int ZLIM_BITS          = 23;
   localparam int ZCMP_BITS          = COORD_BITS + ZLIM_BITS;
   localparam int ZLIM_RESET         = 65536;
   localparam int NUM_ENDS           = 2;
   localparam int CSR_ADDR_BITS      = 3;
   localparam int CSR_DATA_BITS      = 32;
   localparam int REG_Z_LIMIT        = 0;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_TEST   = 2'd2
   } action_type;

   typedef struct packed {
      logic [1:0]                   action;
      logic signed [COORD_BITS-1:0] vertex_x;
      logic signed [COORD_BITS-1:0] vertex_y;
      logic [TAG_BITS-1:0]          bond_tag;
      logic                         end_a_valid;
      logic signed [COORD_BITS-1:0] end_a_x;
      logic signed [COORD_BITS-1:0] end_a_y;
      logic signed [COORD_BITS-1:0] end_a_z;
      logic                         end_b_valid;
      logic signed [COORD_BITS-1:0] end_b_x;
      logic signed [COORD_BITS-1:0] end_b_y;
      logic signed [COORD_BITS-1:0] end_b_z;
   } req_word_type;

   typedef struct packed {
      logic [TAG_BITS-1:0] tag_out;
      logic                selected;
      logic                inside_a;
      logic                inside_b;
      logic                fence_full;
   } rsp_word_type;

   typedef struct packed {
      logic                 capture;
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      logic                 rd_en;
      logic                 rd_first;
      logic [ADDR_BITS-1:0] rd_addr;
      logic                 load_rsp;
      logic                 rsp_flag;
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic rsp_free;
   } sts_type;

endpackage

### rtl/bfps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bfps_ctrl.sv
// Controller of the fence polygon bond selector: vertex count, edge sweep
// sequencing and result hand-off. Depends on bfps_pkg.
module bfps_ctrl
   import bfps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_action,
   output logic       req_stall,
   output cmd_type    cmd,
   input  sts_type    sts
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SWEEP  = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] step_ff, step_in;
   logic                flag_ff, flag_in;
   logic [CNT_BITS-1:0] last_idx;
   logic [CNT_BITS-1:0] prev_step;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      step_in   = step_ff;
      flag_in   = flag_ff;
      req_stall = 1'b1;
      last_idx  = count_ff - CNT_BITS'(1);
      prev_step = step_ff - CNT_BITS'(1);
      cmd          = '0;
      cmd.wr_addr  = count_ff[ADDR_BITS-1:0];
      cmd.rsp_flag = flag_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               unique case (req_action)
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  ACT_APPEND: begin
                     if (count_ff < CNT_BITS'(MAX_FENCE_VERTICES)) begin
                        cmd.wr_en = 1'b1;
                        count_in  = count_ff + CNT_BITS'(1);
                     end else begin
                        flag_in  = 1'b1;
                        state_in = ST_FINISH;
                     end
                  end
                  ACT_TEST: begin
                     cmd.capture = 1'b1;
                     flag_in     = 1'b0;
                     step_in     = '0;
                     if (count_ff == '0) begin
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_SWEEP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_first = (step_ff == '0);
            cmd.rd_addr  = (step_ff == '0) ? last_idx[ADDR_BITS-1:0]
                                           : prev_step[ADDR_BITS-1:0];
            step_in      = step_ff + CNT_BITS'(1);
            if (step_ff == count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         step_ff  <= '0;
         flag_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         step_ff  <= step_in;
         flag_ff  <= flag_in;
      end
   end

endmodule

### rtl/bfps_dpath.sv
// Datapath of the fence polygon bond selector: vertex RAM, edge pipeline with
// cross multiplication, crossing parity per endpoint and the result register.
// Depends on bfps_pkg and bfps_ram.
module bfps_dpath
   import bfps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  req_word_type         req_data,
   input  logic [ZLIM_BITS-1:0] z_limit,
   input  cmd_type              cmd,
   output sts_type              sts,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_word_type         rsp_data
);

   logic [2*COORD_BITS-1:0]      rd_data;
   logic signed [COORD_BITS-1:0] cur_x, cur_y;
   logic                         edge_v;

   logic                         rd_v_ff, rd_first_ff;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_y_ff;

   logic signed [COORD_BITS-1:0] pt_x_ff [NUM_ENDS];
   logic signed [COORD_BITS-1:0] pt_y_ff [NUM_ENDS];
   logic signed [COORD_BITS-1:0] pt_x_in [NUM_ENDS];
   logic signed [COORD_BITS-1:0] pt_y_in [NUM_ENDS];
   logic                         ok_ff   [NUM_ENDS];
   logic                         ok_in   [NUM_ENDS];
   logic [TAG_BITS-1:0]          tag_ff, tag_in;
   logic [COORD_BITS-1:0]        z_mag   [NUM_ENDS];
   logic signed [COORD_BITS-1:0] pt_z    [NUM_ENDS];
   logic                         pt_valid[NUM_ENDS];

   logic                         s1_v_ff;
   logic signed [DIFF_BITS-1:0]  d_ff, d_in, dx_ff, dx_in;
   logic signed [DIFF_BITS-1:0]  dy_ff [NUM_ENDS];
   logic signed [DIFF_BITS-1:0]  dy_in [NUM_ENDS];
   logic signed [DIFF_BITS-1:0]  dp_ff [NUM_ENDS];
   logic signed [DIFF_BITS-1:0]  dp_in [NUM_ENDS];
   logic                         cnt1_ff [NUM_ENDS];
   logic                         cnt1_in [NUM_ENDS];

   logic                         s2_v_ff;
   logic                         dpos_ff, dpos_in;
   logic signed [PROD_BITS-1:0]  lhs_ff [NUM_ENDS];
   logic signed [PROD_BITS-1:0]  lhs_in [NUM_ENDS];
   logic signed [PROD_BITS-1:0]  rhs_ff [NUM_ENDS];
   logic signed [PROD_BITS-1:0]  rhs_in [NUM_ENDS];
   logic                         cnt2_ff [NUM_ENDS];

   logic                         par_ff [NUM_ENDS];
   logic                         par_in [NUM_ENDS];

   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_word_type                 rsp_data_ff, rsp_data_in;

   bfps_ram #(
      .WIDTH (2 * COORD_BITS),
      .DEPTH (MAX_FENCE_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data ({req_data.vertex_x, req_data.vertex_y}),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_data)
   );

   assign cur_x  = rd_data[2*COORD_BITS-1:COORD_BITS];
   assign cur_y  = rd_data[COORD_BITS-1:0];
   assign edge_v = rd_v_ff && !rd_first_ff;

   // Endpoint capture with the depth clip applied up front.
   always_comb begin
      pt_z[0]     = req_data.end_a_z;
      pt_z[1]     = req_data.end_b_z;
      pt_valid[0] = req_data.end_a_valid;
      pt_valid[1] = req_data.end_b_valid;
      tag_in      = cmd.capture ? req_data.bond_tag : tag_ff;
      for (int k = 0; k < NUM_ENDS; k++) begin
         z_mag[k]   = pt_z[k][COORD_BITS-1] ? COORD_BITS'(-pt_z[k]) : COORD_BITS'(pt_z[k]);
         pt_x_in[k] = pt_x_ff[k];
         pt_y_in[k] = pt_y_ff[k];
         ok_in[k]   = ok_ff[k];
      end
      if (cmd.capture) begin
         pt_x_in[0] = req_data.end_a_x;
         pt_y_in[0] = req_data.end_a_y;
         pt_x_in[1] = req_data.end_b_x;
         pt_y_in[1] = req_data.end_b_y;
         for (int k = 0; k < NUM_ENDS; k++) begin
            ok_in[k] = pt_valid[k] && (ZCMP_BITS'(z_mag[k]) < ZCMP_BITS'(z_limit));
         end
      end
   end

   // Edge from the previous vertex to the current one.
   always_comb begin
      d_in  = DIFF_BITS'(prev_y_ff) - DIFF_BITS'(cur_y);
      dx_in = DIFF_BITS'(prev_x_ff) - DIFF_BITS'(cur_x);
      for (int k = 0; k < NUM_ENDS; k++) begin
         dy_in[k]   = DIFF_BITS'(pt_y_ff[k]) - DIFF_BITS'(cur_y);
         dp_in[k]   = DIFF_BITS'(pt_x_ff[k]) - DIFF_BITS'(cur_x);
         cnt1_in[k] = (prev_y_ff != cur_y)
                      && !((pt_y_ff[k] >= prev_y_ff) && (pt_y_ff[k] >= cur_y))
                      && !((pt_y_ff[k] < prev_y_ff) && (pt_y_ff[k] < cur_y));
      end
   end

   always_comb begin
      dpos_in = !d_ff[DIFF_BITS-1];
      for (int k = 0; k < NUM_ENDS; k++) begin
         lhs_in[k] = dy_ff[k] * dx_ff;
         rhs_in[k] = dp_ff[k] * d_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_ENDS; k++) begin
         if (cmd.capture) begin
            par_in[k] = 1'b0;
         end else if (s2_v_ff && cnt2_ff[k]
                      && (dpos_ff ? (lhs_ff[k] >= rhs_ff[k]) : (rhs_ff[k] >= lhs_ff[k]))) begin
            par_in[k] = !par_ff[k];
         end else begin
            par_in[k] = par_ff[k];
         end
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         if (cmd.rsp_flag) begin
            rsp_data_in            = '0;
            rsp_data_in.fence_full = 1'b1;
         end else begin
            rsp_data_in.tag_out    = tag_ff;
            rsp_data_in.inside_a   = ok_ff[0] && par_ff[0];
            rsp_data_in.inside_b   = ok_ff[1] && par_ff[1];
            rsp_data_in.selected   = ok_ff[0] && par_ff[0] && ok_ff[1] && par_ff[1];
            rsp_data_in.fence_full = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff      <= 1'b0;
         rd_first_ff  <= 1'b0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_ENDS; k++) begin
            par_ff[k] <= 1'b0;
            ok_ff[k]  <= 1'b0;
         end
      end else begin
         rd_v_ff      <= cmd.rd_en;
         rd_first_ff  <= cmd.rd_first;
         s1_v_ff      <= edge_v;
         s2_v_ff      <= s1_v_ff;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < NUM_ENDS; k++) begin
            par_ff[k] <= par_in[k];
            ok_ff[k]  <= ok_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_v_ff) begin
         prev_x_ff <= cur_x;
         prev_y_ff <= cur_y;
      end
      tag_ff      <= tag_in;
      d_ff        <= d_in;
      dx_ff       <= dx_in;
      dpos_ff     <= dpos_in;
      rsp_data_ff <= rsp_data_in;
      for (int k = 0; k < NUM_ENDS; k++) begin
         pt_x_ff[k] <= pt_x_in[k];
         pt_y_ff[k] <= pt_y_in[k];
         dy_ff[k]   <= dy_in[k];
         dp_ff[k]   <= dp_in[k];
         cnt1_ff[k] <= cnt1_in[k];
         lhs_ff[k]  <= lhs_in[k];
         rhs_ff[k]  <= rhs_in[k];
         cnt2_ff[k] <= cnt1_ff[k];
      end
   end

   assign sts.pipe_busy = rd_v_ff || s1_v_ff || s2_v_ff;
   assign sts.rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

endmodule

### rtl/bond_fence_polygon_select.sv
// Top level of the fence polygon bond selector, with the z_limit register.
// Depends on bfps_pkg, bfps_ctrl and bfps_dpath.
//
// Clear words, and append words to a fence that is not full, are taken without a
// stall. A test word stalls the next word until its result is handed off. The
// vertex RAM delivers one vertex, and so one polygon edge, per cycle, and both
// endpoints are checked against that edge together; with an empty fence no edge
// is swept, as after an append to a full fence, which returns a flag word. A
// finished result waits in the output register while the next word is taken;
// the block waits in its finish state for as long as the previous result is
// still held there. z_limit lies at byte address 0 and may be written only
// while the block is idle.
module bond_fence_polygon_select
   import bfps_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_word_type             req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_word_type             rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   logic [ZLIM_BITS-1:0] z_limit_ff, z_limit_in;
   logic                 reg_hit;
   cmd_type              cmd;
   sts_type              sts;

   assign reg_hit = (paddr[CSR_ADDR_BITS-1:2] == (CSR_ADDR_BITS-2)'(REG_Z_LIMIT));

   always_comb begin
      z_limit_in = z_limit_ff;
      if (psel && penable && pwrite && reg_hit) begin
         z_limit_in = pwdata[ZLIM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         z_limit_ff <= ZLIM_BITS'(ZLIM_RESET);
      end else begin
         z_limit_ff <= z_limit_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = reg_hit ? CSR_DATA_BITS'(z_limit_ff) : '0;

   bfps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_stall  (req_stall),
      .cmd        (cmd),
      .sts        (sts)
   );

   bfps_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .z_limit   (z_limit_ff),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/bfps_checker.sv
// Port-level checks for the fence polygon bond selector, bound to the top level.
// Depends on bfps_pkg and the assertion macros header.
`include "bond_fence_polygon_select_defines.svh"

module bfps_checker
   import bfps_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_word_type req_data,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   `BFPS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   `BFPS_ASSERT_NOW(a_flag_word_clean, rsp_valid && rsp_data.fence_full, (rsp_data.tag_out == '0) && !rsp_data.selected && !rsp_data.inside_a && !rsp_data.inside_b)

   `BFPS_ASSERT_NOW(a_selected_both, rsp_valid && rsp_data.selected, rsp_data.inside_a && rsp_data.inside_b && !rsp_data.fence_full)

   `BFPS_ASSERT_NEXT(a_test_busy, req_valid && !req_stall && (req_data.action == ACT_TEST), req_stall)

endmodule

bind bond_fence_polygon_select bfps_checker u_checker (.*);
